// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clk edge out of reset
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/hlm_pkg.sv
package hlm_pkg;

	localparam int TIME_W        = 64;
	localparam int LAT_W         = 48;
	localparam int AVG_W         = 49;
	localparam int LIM_W         = 4;
	localparam int IVL_W         = 24;
	localparam int IN_DATA_W     = 192;
	localparam int OUT_DATA_W    = 232;
	localparam int SEND_SLACK_US = 500;
	localparam int US_PER_S      = 1000000;
	localparam int LIMIT_MAX_S   = 10;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_RESP,
		OP_ECHO
	} op_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_REQ,
		KIND_ECHO
	} kind_t;

	typedef enum logic [0:0] {
		REG_LIMIT,
		REG_INTERVAL
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEARCH,
		ST_WIN,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              time_we;
		logic              lat_we;
		logic [TIME_W-1:0] time_data;
		logic [LAT_W-1:0]  lat_data;
	} ring_wr_t;

	// average limit in us; out-of-range settings act as one second
	function automatic logic [IVL_W-1:0] limit_us(input logic [LIM_W-1:0] lim);
		logic [IVL_W-1:0] secs;
		secs = IVL_W'(lim);
		if (lim == '0 || secs > IVL_W'(LIMIT_MAX_S))
			secs = IVL_W'(1);
		return IVL_W'(secs * IVL_W'(US_PER_S));
	endfunction

endpackage

// File: hw/rtl/hlm_ring.sv
module hlm_ring import hlm_pkg::*; #(
	parameter int DEPTH = 30,
	parameter int IW    = 5
) (
	input  logic              clk,
	input  ring_wr_t          wr,
	input  logic [IW-1:0]     wr_addr,
	input  logic [IW-1:0]     rd_addr,
	output logic [TIME_W-1:0] rd_time,
	output logic [LAT_W-1:0]  rd_lat
);

	logic [TIME_W-1:0] time_mem [DEPTH];
	logic [LAT_W-1:0]  lat_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.time_we)
			time_mem[wr_addr] <= wr.time_data;
		rd_time <= time_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.lat_we)
			lat_mem[wr_addr] <= wr.lat_data;
		rd_lat <= lat_mem[rd_addr];
	end

endmodule

// File: hw/rtl/hlm_div.sv
module hlm_div import hlm_pkg::*; #(
	parameter int NW = 52,
	parameter int DW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], fits};
			if (fits)
				rem_q <= DW'(trial - {1'b0, den_q});
			else
				rem_q <= trial[DW-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: hw/rtl/heartbeat_latency_monitor.sv
// channel   direction  tdata (low bit up)                       tuser
// s_axis    in         now_us, msg_seq, msg_sent_us             op
// m_axis    out        out_seq, out_time_us, latency_max_us,    result_kind
//                      latency_avg_us, bad_latency, order_error,
//                      link_down, zero fill
// cfg       in         write enable, register index, write data
//
// tick, echo and unused op: result loaded into the output register after the exec and emit steps
// response: the entries held are searched for the matching send time, then the averaging window
// is read, then the bit-serial divider runs over the dividend width (52 bits by default)
// reset is asynchronous; the history memories are not cleared and need no clearing pass
// a result waits in the output register; the next item is taken meanwhile and the
// sequencer holds in its emit step only while that register is still full
`include "assert_macros.svh"

module heartbeat_latency_monitor import hlm_pkg::*; #(
	parameter int HISTORY_DEPTH  = 30,
	parameter int AVERAGE_WINDOW = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // now_us, msg_seq, msg_sent_us
	input  logic [1:0]            s_axis_tuser,  // op
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // out_seq, out_time_us, latency_max_us,
	                                             // latency_avg_us, bad_latency,
	                                             // order_error, link_down, zero fill
	output logic [1:0]            m_axis_tuser,  // result_kind
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [IVL_W-1:0]      cfg_data
);

	localparam int IW   = $clog2(HISTORY_DEPTH);
	localparam int CNTW = $clog2(HISTORY_DEPTH + 1);
	localparam int WCW  = $clog2(AVERAGE_WINDOW + 1);
	localparam int SW   = LAT_W + WCW;
	localparam logic [IW:0]     DEPTH_W = (IW+1)'(HISTORY_DEPTH);
	localparam logic [CNTW-1:0] DEPTH_C = CNTW'(HISTORY_DEPTH);

	state_t state_q, state_d;

	logic [LIM_W-1:0]  lim_q;
	logic [IVL_W-1:0]  interval_q;

	op_t               op_q;
	logic [TIME_W-1:0] now_q, seq_q, sent_q;

	logic [IW-1:0]     head_q;
	logic [CNTW-1:0]   count_q;
	logic [TIME_W-1:0] next_q;
	logic              started_q;
	logic [TIME_W-1:0] send_cnt_q;
	logic [TIME_W-1:0] last_seq_q;
	logic [LAT_W-1:0]  held_max_q;
	logic [AVG_W-1:0]  held_avg_q;
	logic              dead_q;
	logic [HISTORY_DEPTH-1:0] nz_q;

	logic [LAT_W-1:0]  lat_q;
	logic [IW-1:0]     age_q;
	logic [CNTW-1:0]   rem_q;
	logic              pend_s1;
	logic [IW-1:0]     slot_s1;
	logic [SW-1:0]     sum_q;
	logic [LAT_W-1:0]  max_q;
	logic [WCW-1:0]    nzc_q;

	kind_t             res_kind_q;
	logic [TIME_W-1:0] res_seq_q, res_time_q;
	logic              res_bad_q, res_oerr_q;

	logic                  out_valid_q;
	kind_t                 out_kind_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	ring_wr_t          ring_wr;
	logic [IW-1:0]     wr_addr, rd_addr, push_slot;
	logic [TIME_W-1:0] rd_time;
	logic [LAT_W-1:0]  rd_lat;

	logic              div_start, div_busy, div_done;
	logic [SW-1:0]     div_q;
	logic [WCW-1:0]    divisor;

	logic [TIME_W-1:0] next_eff;
	logic              due, full, hit, emit, dead_d;
	logic [TIME_W:0]   diff;
	logic [LAT_W-1:0]  lat_new;
	logic [CNTW-1:0]   win_len;
	logic [LAT_W-1:0]  avg_new;

	function automatic logic [IW-1:0] wrap_idx(input logic [IW-1:0] h, input logic [IW-1:0] a);
		logic [IW:0] s;
		s = {1'b0, h} + {1'b0, a};
		if (s >= DEPTH_W)
			s = s - DEPTH_W;
		return s[IW-1:0];
	endfunction

	hlm_ring #(
		.DEPTH(HISTORY_DEPTH),
		.IW   (IW)
	) u_ring (
		.clk    (clk),
		.wr     (ring_wr),
		.wr_addr(wr_addr),
		.rd_addr(rd_addr),
		.rd_time(rd_time),
		.rd_lat (rd_lat)
	);

	hlm_div #(
		.NW(SW),
		.DW(WCW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q),
		.divisor (divisor),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(div_q)
	);

	assign next_eff  = started_q ? next_q : now_q;
	assign due       = ({1'b0, now_q} + (TIME_W+1)'(SEND_SLACK_US)) >= {1'b0, next_eff};
	assign full      = count_q == DEPTH_C;
	assign push_slot = full ? head_q : wrap_idx(head_q, count_q[IW-1:0]);
	assign rd_addr   = wrap_idx(head_q, age_q);
	assign hit       = pend_s1 && (rd_time == sent_q);
	assign diff      = {1'b0, now_q} - {1'b0, sent_q};
	assign lat_new   = diff[TIME_W] ? '0 :
	                   (|diff[TIME_W-1:LAT_W]) ? '1 : diff[LAT_W-1:0];
	assign win_len   = (32'(count_q) > AVERAGE_WINDOW) ? CNTW'(AVERAGE_WINDOW) : count_q;
	assign divisor   = (nzc_q == '0) ? WCW'(1) : nzc_q;
	assign avg_new   = div_q[LAT_W-1:0];
	assign emit      = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
	assign dead_d    = dead_q || (full && nz_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d           = state_q;
		ring_wr           = '0;
		wr_addr           = push_slot;
		div_start         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_EMIT;
				if (!dead_q) begin
					case (op_q)
						OP_TICK: begin
							if (due) begin
								ring_wr.time_we   = 1'b1;
								ring_wr.lat_we    = 1'b1;
								ring_wr.time_data = now_q;
								ring_wr.lat_data  = '0;
							end
						end
						OP_RESP: state_d = ST_SEARCH;
						default: state_d = ST_EMIT;
					endcase
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					ring_wr.lat_we   = 1'b1;
					ring_wr.lat_data = lat_q;
					wr_addr          = slot_s1;
					state_d          = ST_WIN;
				end else if (rem_q == '0 && !pend_s1) begin
					state_d = ST_WIN;
				end
			end
			ST_WIN: begin
				if (rem_q == '0 && !pend_s1) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q      <= LIM_W'(1);
			interval_q <= IVL_W'(100000);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LIMIT:    lim_q      <= cfg_data[LIM_W-1:0];
				REG_INTERVAL: interval_q <= cfg_data;
				default:      lim_q      <= lim_q;
			endcase
		end
	end

	// architectural state and sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			next_q      <= '0;
			started_q   <= 1'b0;
			send_cnt_q  <= '0;
			last_seq_q  <= '0;
			held_max_q  <= '0;
			held_avg_q  <= '1;
			dead_q      <= 1'b0;
			nz_q        <= '0;
			age_q       <= '0;
			rem_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ring_wr.lat_we)
				nz_q[wr_addr] <= ring_wr.lat_data != '0;
			case (state_q)
				ST_EXEC: begin
					if (!dead_q) begin
						case (op_q)
							OP_TICK: begin
								started_q <= 1'b1;
								if (due) begin
									if (full)
										head_q <= wrap_idx(head_q, IW'(1));
									else
										count_q <= count_q + 1'b1;
									send_cnt_q <= send_cnt_q + 1'b1;
									next_q     <= next_eff + TIME_W'(interval_q);
								end else begin
									next_q <= next_eff;
								end
							end
							OP_RESP: begin
								last_seq_q <= seq_q;
								age_q      <= IW'(count_q - 1'b1);
								rem_q      <= count_q;
								pend_s1    <= 1'b0;
							end
							default: last_seq_q <= last_seq_q;
						endcase
					end
				end
				ST_SEARCH, ST_WIN: begin
					if (state_q == ST_SEARCH && state_d == ST_WIN) begin
						age_q   <= IW'(count_q - 1'b1);
						rem_q   <= win_len;
						pend_s1 <= 1'b0;
					end else if (rem_q != '0) begin
						pend_s1 <= 1'b1;
						rem_q   <= rem_q - 1'b1;
						age_q   <= age_q - 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						held_max_q <= max_q;
						held_avg_q <= {1'b0, avg_new};
					end
				end
				ST_EMIT: begin
					if (emit)
						dead_q <= dead_d;
				end
				default: pend_s1 <= 1'b0;
			endcase
			if (emit)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					op_q       <= op_t'(s_axis_tuser);
					now_q      <= s_axis_tdata[63:0];
					seq_q      <= s_axis_tdata[127:64];
					sent_q     <= s_axis_tdata[191:128];
					res_kind_q <= KIND_NONE;
					res_seq_q  <= '0;
					res_time_q <= '0;
					res_bad_q  <= 1'b0;
					res_oerr_q <= 1'b0;
				end
			end
			ST_EXEC: begin
				if (!dead_q) begin
					case (op_q)
						OP_TICK: begin
							if (due) begin
								res_kind_q <= KIND_REQ;
								res_seq_q  <= send_cnt_q + 1'b1;
								res_time_q <= now_q;
							end
						end
						OP_RESP: begin
							res_oerr_q <= seq_q != (last_seq_q + 1'b1);
							lat_q      <= lat_new;
						end
						OP_ECHO: begin
							res_kind_q <= KIND_ECHO;
							res_seq_q  <= seq_q;
							res_time_q <= sent_q;
						end
						default: res_kind_q <= KIND_NONE;
					endcase
				end
			end
			ST_SEARCH: begin
				slot_s1 <= rd_addr;
				sum_q   <= '0;
				max_q   <= '0;
				nzc_q   <= '0;
			end
			ST_WIN: begin
				if (pend_s1) begin
					sum_q <= sum_q + SW'(rd_lat);
					if (rd_lat > max_q)
						max_q <= rd_lat;
					if (rd_lat != '0)
						nzc_q <= nzc_q + 1'b1;
				end
			end
			ST_DIV: begin
				if (div_done)
					res_bad_q <= avg_new > LAT_W'(limit_us(lim_q));
			end
			default: slot_s1 <= slot_s1;
		endcase
		if (emit) begin
			out_kind_q <= res_kind_q;
			out_data_q <= {4'b0, dead_d, res_oerr_q, res_bad_q, held_avg_q, held_max_q,
			               res_time_q, res_seq_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;

	`ASSERT_NEXT(a_dead_sticky, dead_q, dead_q)
	`ASSERT_IMPLIES(a_dead_silent, state_q == ST_EMIT && dead_q, res_kind_q == KIND_NONE)
	`ASSERT_IMPLIES(a_div_owner, div_busy, state_q == ST_DIV)
	`ASSERT_NEXT(a_emit_loads, emit, m_axis_tvalid)

endmodule
